/* rtl/ffba_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam logic [1:0] OP_ALLOC  = 2'd0;
  localparam logic [1:0] OP_FREE   = 2'd1;
  localparam logic [1:0] OP_RESIZE = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [1:0] ST_DONE    = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_IGNORED = 2'd2;

  localparam logic REG_HEAP_ORIGIN = 1'b0;
  localparam logic REG_HEAP_SPAN   = 1'b1;

  localparam int OFFSET_W = 24;
  localparam int BYTES_W  = 24;
  localparam int ENTRY_W  = OFFSET_W + BYTES_W + 1;

  // one table entry as stored in the block table
  typedef struct packed {
    logic [OFFSET_W-1:0] offset;
    logic [BYTES_W-1:0]  bytes;
    logic                free;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/ffba_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ffba_ram
// Generic single-port-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ffba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* rtl/first_fit_block_allocator.sv */
`timescale 1ns / 1ps
`default_nettype none
// flow: an unused opcode, a null free or a zero-size allocate goes from the
//   accepted transaction straight to the result; each entry visited in a walk
//   is read and then checked, a split or merge moves one entry per read and write
//   pair of states, and the merge pass reads both entries of a pair before checking
// throughput: one transaction at a time, the next one taken once the result is accepted
// reset: synchronous; clears pool_ready, block count and handshakes, table not cleared
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap manager with split and coalesce, driven by a sequencer that
// walks the block table held in a RAM.
// ----------------------------------------------------------------------------
module first_fit_block_allocator
  import ffba_pkg::*;
#(
  parameter int MAX_BLOCKS   = 64,
  parameter int HEADER_BYTES = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  opcode,
  input  wire logic [31:0] address,
  input  wire logic [24:0] request_size,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      result_address,
  output logic [24:0]      copy_bytes,
  output logic [1:0]       status
);

  localparam int IW = $clog2(MAX_BLOCKS);
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam logic [CW-1:0] CMAX = CW'(MAX_BLOCKS);
  localparam logic [31:0] HDR = 32'(HEADER_BYTES);

  // sequencer states
  typedef enum logic [15:0] {
    S_IDLE    = 16'b0000000000000001,
    S_DISP    = 16'b0000000000000010,
    S_FRD     = 16'b0000000000000100,
    S_FCHK    = 16'b0000000000001000,
    S_GRD     = 16'b0000000000010000,
    S_GCHK    = 16'b0000000000100000,
    S_SHRD    = 16'b0000000001000000,
    S_SHWR    = 16'b0000000010000000,
    S_GFIN    = 16'b0000000100000000,
    S_MRD     = 16'b0000001000000000,
    S_MCHK    = 16'b0000010000000000,
    S_MVRD    = 16'b0000100000000000,
    S_MVWR    = 16'b0001000000000000,
    S_ORD     = 16'b0010000000000000,
    S_OCHK    = 16'b0100000000000000,
    S_OUT     = 16'b1000000000000000
  } state_t;

  // what to do after a walk finishes
  typedef enum logic [2:0] {
    M_ALLOC  = 3'b001,
    M_FREE   = 3'b010,
    M_RESIZE = 3'b100
  } mode_t;

  state_t state;
  mode_t  mode;

  logic [31:0]   heap_origin;
  logic [24:0]   heap_span;
  logic          pool_ready;
  logic [CW-1:0] count;

  logic [1:0]    op_r;
  logic [31:0]   addr_r;
  logic [25:0]   size4;
  logic [CW-1:0] idx;       // walk index
  logic [CW-1:0] j;         // move index
  logic [CW-1:0] hit;       // granted or found entry
  logic          moving;    // resize grant in progress
  logic [23:0]   old_off;
  logic [23:0]   old_bytes;
  logic [1:0]    merge_rd;  // entries fetched in merge check
  entry_t        cur;       // held entry i
  entry_t        hold;      // split remainder or merged entry

  // ram port
  logic          we;
  logic [IW-1:0] waddr, raddr;
  entry_t        wdata, rdata;

  ffba_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_BLOCKS)) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  // shared address compare and fit arithmetic
  logic [31:0] data_addr;
  logic [31:0] next_off;
  logic        fits, can_split;
  assign data_addr = heap_origin + {8'd0, rdata.offset} + HDR;
  assign next_off  = {8'd0, rdata.offset} + HDR + {6'd0, size4};
  assign fits      = rdata.free && ({8'd0, rdata.bytes} >= {6'd0, size4});
  assign can_split = ({8'd0, rdata.bytes} >= {6'd0, size4} + HDR + 32'd32) &&
                     (next_off + HDR < {7'd0, heap_span}) && (count < CMAX);

  assign cfg_ready = (state == S_IDLE) && !in_valid;
  assign in_ready  = (state == S_IDLE);

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      heap_origin <= '0;
      heap_span   <= 25'd65536;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_HEAP_ORIGIN: heap_origin <= cfg_data;
        REG_HEAP_SPAN:   heap_span   <= cfg_data[24:0];
        default: ;
      endcase
    end
  end

  // ram control, combinational from state
  always_comb begin
    we    = 1'b0;
    waddr = idx[IW-1:0];
    wdata = cur;
    raddr = idx[IW-1:0];
    unique case (state)
      S_DISP: begin
        we    = !pool_ready && ({7'd0, heap_span} >= HDR + 32'd64) && (op_r != OP_UNUSED);
        waddr = '0;
        wdata = '{offset: '0, bytes: 24'({7'd0, heap_span} - HDR), free: 1'b1};
      end
      S_SHRD:  raddr = IW'(j - 1'b1);
      S_SHWR: begin
        // last step of the shift places the split remainder
        we = 1'b1; waddr = j[IW-1:0];
        wdata = (j == hit + 1'b1) ? hold : rdata;
      end
      S_GFIN: begin
        we = 1'b1; waddr = hit[IW-1:0]; wdata = cur;
      end
      // mark the released block free
      S_OCHK: begin
        we    = (mode == M_FREE) || (rdata.offset == old_off);
        wdata = '{offset: rdata.offset, bytes: rdata.bytes, free: 1'b1};
      end
      S_MRD:   raddr = (merge_rd == 2'd0) ? idx[IW-1:0] : IW'(idx + 1'b1);
      // store the merged entry while the tail moves down
      S_MVRD: begin
        we = 1'b1; waddr = idx[IW-1:0]; wdata = hold;
        raddr = IW'(j + 1'b1);
      end
      S_MVWR: begin
        we = 1'b1; waddr = j[IW-1:0]; wdata = rdata;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      pool_ready <= 1'b0;
      count      <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            op_r           <= opcode;
            addr_r         <= address;
            size4          <= ({1'b0, request_size} + 26'd3) & ~26'd3;
            result_address <= '0;
            copy_bytes     <= '0;
            status         <= ST_DONE;
            moving         <= 1'b0;
            idx            <= '0;
            state          <= S_DISP;
          end
        end
        S_DISP: begin
          if (op_r == OP_UNUSED) begin
            status <= ST_IGNORED;
            state  <= S_OUT;
          end else begin
            if (we) begin
              pool_ready <= 1'b1;
              count      <= CW'(1);
            end
            if (op_r == OP_ALLOC || (op_r == OP_RESIZE && addr_r == '0)) begin
              mode <= M_ALLOC;
              if (size4 == '0) begin
                status <= ST_NOFIT;
                state  <= S_OUT;
              end else begin
                state <= S_GRD;
              end
            end else if (op_r == OP_FREE || size4 == '0) begin
              mode  <= M_FREE;
              state <= (addr_r == '0) ? S_OUT : S_FRD;
            end else begin
              mode  <= M_RESIZE;
              state <= S_FRD;
            end
          end
        end
        // find walk
        S_FRD: begin
          if (idx >= count) begin
            status <= ST_IGNORED;
            state  <= S_OUT;
          end else begin
            state <= S_FCHK;
          end
        end
        S_FCHK: begin
          if (data_addr == addr_r) begin
            if (mode == M_FREE) begin
              hit   <= idx;
              cur   <= rdata;
              state <= S_ORD;  // release path
            end else if ({8'd0, rdata.bytes} >= {6'd0, size4}) begin
              result_address <= addr_r;
              state          <= S_OUT;
            end else begin
              old_off   <= rdata.offset;
              old_bytes <= rdata.bytes;
              moving    <= 1'b1;
              idx       <= '0;
              state     <= S_GRD;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_FRD;
          end
        end
        // grant walk
        S_GRD: begin
          if (idx >= count) begin
            status <= ST_NOFIT;
            state  <= S_OUT;
          end else begin
            state <= S_GCHK;
          end
        end
        S_GCHK: begin
          if (fits) begin
            hit <= idx;
            cur <= '{offset: rdata.offset,
                     bytes: can_split ? size4[23:0] : rdata.bytes,
                     free: 1'b0};
            result_address <= data_addr;
            if (can_split) begin
              hold      <= '{offset: next_off[23:0],
                             bytes: 24'({8'd0, rdata.bytes} - {6'd0, size4} - HDR),
                             free: 1'b1};
              j         <= count;
              state     <= S_SHRD;
            end else begin
              state <= S_GFIN;
            end
          end else begin
            idx   <= idx + 1'b1;
            state <= S_GRD;
          end
        end
        S_SHRD: begin
          state <= S_SHWR;
        end
        S_SHWR: begin
          if (j > hit + 1'b1) begin
            j     <= j - 1'b1;
            state <= S_SHRD;
          end else begin
            count <= count + 1'b1;
            state <= S_GFIN;
          end
        end
        S_GFIN: begin
          if (moving) begin
            copy_bytes <= {1'b0, old_bytes};
            idx        <= '0;
            state      <= S_ORD;
          end else begin
            state <= S_OUT;
          end
        end
        // locate old block by offset, or mark found block free, then merge
        S_ORD: begin
          if (mode == M_FREE) begin
            state <= S_OCHK;
          end else if (idx >= count) begin
            state <= S_OUT;
          end else begin
            state <= S_OCHK;
          end
        end
        S_OCHK: begin
          if (mode == M_FREE || rdata.offset == old_off) begin
            mode     <= M_FREE;
            idx      <= '0;
            merge_rd <= 2'd0;
            state    <= S_MRD;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_ORD;
          end
        end
        // merge pass
        S_MRD: begin
          if (idx + 1'b1 >= count) begin
            state <= S_OUT;
          end else begin
            merge_rd <= merge_rd + 1'b1;
            state    <= S_MCHK;
          end
        end
        S_MCHK: begin
          if (merge_rd == 2'd1) begin
            hold     <= rdata;
            state    <= S_MRD;
          end else begin
            merge_rd <= 2'd0;
            if (hold.free && rdata.free) begin
              hold.bytes <= 24'({8'd0, hold.bytes} + HDR + {8'd0, rdata.bytes});
              j          <= idx + 1'b1;
              state      <= S_MVRD;
            end else begin
              idx   <= idx + 1'b1;
              state <= S_MRD;
            end
          end
        end
        S_MVRD: begin
          if (j + 1'b1 >= count) begin
            count <= count - 1'b1;
            state <= S_MVWR;
          end else begin
            state <= S_MVWR;
          end
        end
        S_MVWR: begin
          if (j + 1'b1 >= count + 1'b1 || j + 1'b1 >= count) begin
            state <= S_MRD;
          end else begin
            j     <= j + 1'b1;
            state <= S_MVRD;
          end
        end
        S_OUT: begin
          if (out_valid && out_ready) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // assertions
  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= CMAX)
    else $error("block count above table depth");
  a_busy_no_accept: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready)
    else $error("input ready while busy");
  a_cfg_idle: assert property (@(posedge clk) disable iff (rst)
    cfg_ready |-> (state == S_IDLE))
    else $error("config taken while busy");

endmodule
`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the first-fit block allocator: a shadow heap table
// predicts every grant, free and resize, with random sender bursts, receiver
// stalls and pool settings changed between idle phases.
// ----------------------------------------------------------------------------
module tb;
  import ffba_pkg::*;

  localparam int MAXB = 64;
  localparam int HDR  = 12;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] addr;
    logic [24:0] size;
  } heap_req_t;

  typedef struct {
    logic [31:0] addr;
    logic [24:0] copy;
    logic [1:0]  st;
  } heap_outcome_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = REG_HEAP_ORIGIN;
  logic [31:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_ALLOC;
  logic [31:0] address = '0;
  logic [24:0] request_size = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] result_address;
  logic [24:0] copy_bytes;
  logic [1:0]  status;

  first_fit_block_allocator dut (.*);

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow heap state
  logic [31:0] heap_origin_q = 32'd0;
  logic [31:0] heap_span_q = 32'd65536;
  logic [31:0] heap_off  [MAXB];
  logic [31:0] heap_len  [MAXB];
  bit          heap_free [MAXB];
  int          heap_count = 0;
  bit          heap_ready = 0;
  logic [31:0] last_grant = '0;

  heap_req_t     request_q[$];
  heap_outcome_t outcome_q[$];
  int            errors = 0;

  function automatic logic [31:0] data_at(int i);
    return heap_origin_q + heap_off[i] + HDR;
  endfunction

  function automatic int find_listed(logic [31:0] a);
    for (int i = 0; i < heap_count; i++)
      if (data_at(i) == a) return i;
    return -1;
  endfunction

  // first fit with split of a large enough remainder
  function automatic int carve(logic [31:0] sz);
    logic [31:0] need;
    logic [31:0] next_off;
    need = (sz + 32'd3) & ~32'd3;
    for (int i = 0; i < heap_count; i++) begin
      if (!heap_free[i] || heap_len[i] < need) continue;
      next_off = heap_off[i] + HDR + need;
      if (heap_len[i] >= need + HDR + 32 && next_off + HDR < heap_span_q &&
          heap_count < MAXB) begin
        for (int j = heap_count; j > i + 1; j--) begin
          heap_off[j]  = heap_off[j-1];
          heap_len[j]  = heap_len[j-1];
          heap_free[j] = heap_free[j-1];
        end
        heap_off[i+1]  = next_off & 32'hFFFFFF;
        heap_len[i+1]  = (heap_len[i] - need - HDR) & 32'hFFFFFF;
        heap_free[i+1] = 1;
        heap_len[i]    = need & 32'hFFFFFF;
        heap_count++;
      end
      heap_free[i] = 0;
      return i;
    end
    return -1;
  endfunction

  // mark free, then merge adjacent free pairs
  function automatic void give_back(int idx);
    int i;
    i = 0;
    heap_free[idx] = 1;
    while (i + 1 < heap_count) begin
      if (heap_free[i] && heap_free[i+1]) begin
        heap_len[i] = (heap_len[i] + HDR + heap_len[i+1]) & 32'hFFFFFF;
        for (int j = i + 1; j + 1 < heap_count; j++) begin
          heap_off[j]  = heap_off[j+1];
          heap_len[j]  = heap_len[j+1];
          heap_free[j] = heap_free[j+1];
        end
        heap_count--;
      end else begin
        i++;
      end
    end
  endfunction

  function automatic heap_outcome_t heap_apply(heap_req_t r);
    heap_outcome_t o;
    int idx;
    int nidx;
    logic [31:0] old_off;
    logic [31:0] old_len;
    logic [31:0] sz;
    o = '{32'd0, 25'd0, ST_DONE};
    sz = {7'd0, r.size};
    if (r.op == OP_UNUSED) begin
      o.st = ST_IGNORED;
      return o;
    end
    // lazy pool setup
    if (!heap_ready && heap_span_q >= HDR + 64) begin
      heap_off[0] = 0;
      heap_len[0] = (heap_span_q - HDR) & 32'hFFFFFF;
      heap_free[0] = 1;
      heap_count = 1;
      heap_ready = 1;
    end
    if (r.op == OP_ALLOC || (r.op == OP_RESIZE && r.addr == 0)) begin
      if (sz == 0) o.st = ST_NOFIT;
      else begin
        idx = carve(sz);
        if (idx < 0) o.st = ST_NOFIT;
        else o.addr = data_at(idx);
      end
    end else if (r.op == OP_FREE || sz == 0) begin
      if (r.addr != 0) begin
        idx = find_listed(r.addr);
        if (idx < 0) o.st = ST_IGNORED;
        else give_back(idx);
      end
    end else begin
      idx = find_listed(r.addr);
      if (idx < 0) o.st = ST_IGNORED;
      else if (heap_len[idx] >= ((sz + 32'd3) & ~32'd3)) o.addr = r.addr;
      else begin
        old_off = heap_off[idx];
        old_len = heap_len[idx];
        nidx = carve(sz);
        if (nidx < 0) o.st = ST_NOFIT;
        else begin
          o.addr = data_at(nidx);
          o.copy = old_len[24:0];
          for (int i = 0; i < heap_count; i++)
            if (heap_off[i] == old_off) begin
              give_back(i);
              break;
            end
        end
      end
    end
    if (o.addr != 0) last_grant = o.addr;
    return o;
  endfunction

  task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
    $display("%0t mismatch on %s: got %h, expected %h", $time, field, got, want);
    errors++;
  endtask

  // request driver: bursts with random gaps
  heap_req_t drv_req;
  bit        in_taken = 0;
  int        burst_left = 4;
  int        gap_left = 0;

  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 0;
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        drv_req = request_q.pop_front();
        in_valid <= 1'b1;
        opcode <= drv_req.op;
        address <= drv_req.addr;
        request_size <= drv_req.size;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result receiver: stall pattern is picked anew from four modes when its run ends
  int rx_mode = 0;
  int rx_left = 0;

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_left = $urandom_range(10, 60);
    end
    rx_left--;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (rx_left % 7 != 0);
    endcase
  end

  // monitor: check results, predict on accepted requests
  heap_outcome_t mon_exp;
  heap_req_t     mon_req;

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t result with no request outstanding", $time);
          errors++;
        end else begin
          mon_exp = outcome_q.pop_front();
          if (result_address !== mon_exp.addr)
            report_mismatch("result_address", result_address, mon_exp.addr);
          if (copy_bytes !== mon_exp.copy)
            report_mismatch("copy_bytes", {7'd0, copy_bytes}, {7'd0, mon_exp.copy});
          if (status !== mon_exp.st)
            report_mismatch("status", {30'd0, status}, {30'd0, mon_exp.st});
        end
      end
      if (in_valid && in_ready) begin
        mon_req = '{opcode, address, request_size};
        outcome_q.push_back(heap_apply(mon_req));
        in_taken = 1;
      end
    end
  end

  task automatic wait_idle();
    while (request_q.size() > 0 || in_valid || outcome_q.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    if (idx == REG_HEAP_ORIGIN) heap_origin_q = value;
    else heap_span_q = value & 32'h1FFFFFF;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic issue(logic [1:0] op, logic [31:0] a, logic [24:0] sz);
    request_q.push_back('{op, a, sz});
    wait_idle();
  endtask

  function automatic logic [24:0] pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 25'($urandom_range(1, 256));
    if (r < 90) return 25'($urandom_range(257, 4096));
    if (r < 97) return 25'($urandom_range(0, 65536));
    if (r < 99) return 25'($urandom);
    return 25'd16777216;
  endfunction

  function automatic logic [31:0] pick_listed();
    if (heap_count == 0) return $urandom;
    return data_at($urandom_range(0, heap_count - 1));
  endfunction

  function automatic heap_req_t make_request();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return '{OP_ALLOC, 32'd0, pick_size()};
    if (r < 65) return '{OP_FREE, pick_listed(), 25'd0};
    if (r < 84) return '{OP_RESIZE, pick_listed(), pick_size()};
    if (r < 88) return '{OP_RESIZE, pick_listed(), 25'd0};
    if (r < 92) return '{OP_RESIZE, 32'd0, pick_size()};
    if (r < 95) return '{OP_FREE, 32'd0, 25'($urandom)};
    return '{2'($urandom_range(1, 2)), $urandom, 25'($urandom)};
  endfunction

  // timeout
  initial begin
    #100ms;
    $display("Test completed with failures");
    $finish;
  end

  // stimulus
  logic [31:0] a1;
  logic [31:0] a2;
  int          sent;
  int          batch;

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // pool too small: setup keeps failing
    write_reg(REG_HEAP_SPAN, 32'd40);
    issue(OP_ALLOC, 32'd0, 25'd8);
    issue(OP_FREE, 32'h0000_0010, 25'd0);
    issue(OP_FREE, 32'd0, 25'd0);
    issue(OP_RESIZE, 32'h0000_0010, 25'd4);

    // directed cases on a normal pool
    write_reg(REG_HEAP_ORIGIN, 32'h0000_1000);
    write_reg(REG_HEAP_SPAN, 32'd65536);
    issue(OP_ALLOC, 32'd0, 25'd0);
    issue(OP_ALLOC, 32'd0, 25'd1);
    a1 = last_grant;
    issue(OP_ALLOC, 32'd0, 25'd100);
    a2 = last_grant;
    issue(OP_ALLOC, 32'd0, 25'd16777216);
    issue(OP_FREE, 32'd0, 25'd0);
    issue(OP_FREE, a1, 25'd0);
    issue(OP_FREE, a1, 25'd0);
    issue(OP_RESIZE, 32'd0, 25'd8);
    issue(OP_RESIZE, a2, 25'd40);
    issue(OP_RESIZE, a2, 25'd300);
    a2 = last_grant;
    issue(OP_RESIZE, a2, 25'd0);
    issue(OP_RESIZE, 32'hDEAD_BEEF, 25'd5);
    issue(OP_FREE, 32'hFFFF_FFFF, 25'd0);
    issue(OP_UNUSED, 32'hFFFF_FFFF, 25'h1FFFFFF);
    issue(OP_ALLOC, 32'd0, 25'd64);
    a1 = last_grant;
    issue(OP_RESIZE, a1, 25'd16777216);

    // random phases, pool settings changed while idle
    sent = 0;
    while (sent < 700) begin
      if (sent % 100 < 20) begin
        wait_idle();
        case ($urandom_range(0, 5))
          0: write_reg(REG_HEAP_ORIGIN, 32'd0);
          1: write_reg(REG_HEAP_ORIGIN, 32'hFFFF_FFF0);
          2: write_reg(REG_HEAP_ORIGIN, $urandom);
          3: write_reg(REG_HEAP_SPAN, 32'd16777216);
          4: write_reg(REG_HEAP_SPAN, ($urandom_range(0, 1) == 0) ? 32'd76 : 32'd0);
          default: write_reg(REG_HEAP_SPAN, 32'd65536);
        endcase
      end
      batch = $urandom_range(5, 40);
      for (int k = 0; k < batch; k++) request_q.push_back(make_request());
      sent += batch;
      // let every result come back before refreshing the address picks
      wait_idle();
    end

    wait_idle();
    repeat (200) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
